FILE: hdl/clc_pkg.sv
// ============================================================================
// clc_pkg - shared types and constants for the line/arc connection pipeline
// Widths of the intermediate values and the sideband records that travel
// beside the pipelined dividers.
// ============================================================================
package clc_pkg;

  // Pi in Q3.13 radians.
  localparam int PI_Q13 = 25736;

  // Main divider: 64-bit dividend magnitude, divisor 1 - cos in Q.28 (< 2^30).
  localparam int NUM_W = 64;
  localparam int DEN_W = 30;
  localparam int QUO_W = NUM_W + 1;

  // Curvature divider: 2^32 divided by a radius of at most 2^32.
  localparam int CRV_W = 33;

  // Magnitude of a relative coordinate (at most 2^33).
  localparam int PX_W   = 34;
  // Relative heading once it is known to lie in [0, pi].
  localparam int TH_W   = 15;
  // Signed line lengths before saturation.
  localparam int LEN_W  = 66;
  // Radius bits kept for the arc length product; larger radii saturate.
  localparam int RAD_W  = 44;
  localparam int PROD_W = RAD_W + TH_W;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STRAIGHT = 2'd0;
  localparam kind_t KIND_LEFT     = 2'd1;
  localparam kind_t KIND_RIGHT    = 2'd2;

  // Sideband that rides along the main dividers.
  typedef struct packed {
    logic            reject;
    logic            straight;
    logic            py_pos;
    logic            xs;
    logic            ys;
    logic [PX_W-1:0] px;
    logic [TH_W-1:0] th;
  } side1_t;

  // Sideband that rides along the curvature divider.
  typedef struct packed {
    logic                    found;
    logic                    straight;
    logic                    line_lead;
    logic                    xs;
    logic                    ys;
    logic signed [LEN_W-1:0] len;
    logic                    arc_zero;
    logic                    arc_big;
    logic [PROD_W-1:0]       prod;
    logic                    csat;
    logic                    czero;
  } side2_t;

endpackage

FILE: hdl/clc_div.sv
// ============================================================================
// clc_div - pipelined restoring divider with floor rounding
// One quotient bit per register stage; the dividend comes as magnitude and
// sign, the divisor is positive.
// ============================================================================
module clc_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 30
) (
  input  logic                    clk,
  input  logic [NUM_W-1:0]        num,
  input  logic                    neg,
  input  logic [DEN_W-1:0]        den,
  output logic signed [NUM_W:0]   quo
);

  logic [DEN_W-1:0] rem    [NUM_W];
  logic [NUM_W-1:0] nq     [NUM_W];
  logic [DEN_W-1:0] den_s  [NUM_W];
  logic             neg_s  [NUM_W];

  logic [DEN_W-1:0] rem_in [NUM_W];
  logic [NUM_W-1:0] nq_in  [NUM_W];
  logic [DEN_W-1:0] den_in [NUM_W];
  logic             neg_in [NUM_W];
  logic [DEN_W:0]   trial  [NUM_W];
  logic [DEN_W:0]   diff   [NUM_W];
  logic             ge     [NUM_W];

  logic [NUM_W:0]   q_ext;
  logic [NUM_W:0]   q_inc;

  always_comb begin
    rem_in[0] = '0;
    nq_in[0]  = num;
    den_in[0] = den;
    neg_in[0] = neg;
    for (int i = 1; i < NUM_W; i++) begin
      rem_in[i] = rem[i-1];
      nq_in[i]  = nq[i-1];
      den_in[i] = den_s[i-1];
      neg_in[i] = neg_s[i-1];
    end
    for (int i = 0; i < NUM_W; i++) begin
      trial[i] = {rem_in[i], nq_in[i][NUM_W-1]};
      diff[i]  = trial[i] - {1'b0, den_in[i]};
      ge[i]    = trial[i] >= {1'b0, den_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_W; i++) begin
      rem[i]   <= ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
      nq[i]    <= {nq_in[i][NUM_W-2:0], ge[i]};
      den_s[i] <= den_in[i];
      neg_s[i] <= neg_in[i];
    end
  end

  // A negative dividend with a remainder rounds one step further down.
  assign q_ext = {1'b0, nq[NUM_W-1]};
  assign q_inc = q_ext + {{NUM_W{1'b0}}, (rem[NUM_W-1] != '0)};

  always_ff @(posedge clk) begin
    quo <= neg_s[NUM_W-1] ? $signed(-q_inc) : $signed(q_ext);
  end

endmodule

FILE: hdl/clc_dly.sv
// ============================================================================
// clc_dly - valid and sideband delay line
// Carries a beat's valid bit and side data past a pipelined unit.
// ============================================================================
module clc_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [W-1:0] data [DEPTH];
  logic         vld  [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    data[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) data[i] <= data[i-1];
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

FILE: hdl/clc_front.sv
// ============================================================================
// clc_front - relative pose transform and divider operand preparation
// Seven register stages: differences, rotation products, rounding, mirroring,
// numerator products, numerator sums, and sign/magnitude split.
// ============================================================================
module clc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [31:0]   start_x,
  input  logic signed [31:0]   start_y,
  input  logic signed [15:0]   start_heading,
  input  logic signed [15:0]   start_cos,
  input  logic signed [15:0]   start_sin,
  input  logic signed [31:0]   goal_x,
  input  logic signed [31:0]   goal_y,
  input  logic signed [15:0]   goal_heading,
  input  logic signed [15:0]   goal_cos,
  input  logic signed [15:0]   goal_sin,
  output logic                 out_valid,
  output logic [clc_pkg::NUM_W-1:0] nq_mag,
  output logic                 nq_neg,
  output logic [clc_pkg::NUM_W-1:0] nr_mag,
  output logic [clc_pkg::NUM_W-1:0] n2_mag,
  output logic                 n2_neg,
  output logic [clc_pkg::DEN_W-1:0] om,
  output clc_pkg::side1_t      side
);
  import clc_pkg::*;

  function automatic logic signed [15:0] clamp_unit(input logic signed [15:0] v);
    if (v > 16'sd16384) return 16'sd16384;
    if (v < -16'sd16384) return -16'sd16384;
    return v;
  endfunction

  logic v1, v2, v3, v4, v5, v6;

  // Stage 1: position and heading differences, clamped tangents.
  logic signed [32:0] dx1, dy1;
  logic signed [16:0] th1;
  logic signed [15:0] cs1, ss1, cg1, sg1;

  always_ff @(posedge clk) begin
    dx1 <= {goal_x[31], goal_x} - {start_x[31], start_x};
    dy1 <= {goal_y[31], goal_y} - {start_y[31], start_y};
    th1 <= {goal_heading[15], goal_heading} - {start_heading[15], start_heading};
    cs1 <= clamp_unit(start_cos);
    ss1 <= clamp_unit(start_sin);
    cg1 <= clamp_unit(goal_cos);
    sg1 <= clamp_unit(goal_sin);
  end

  // Stage 2: rotation products and heading wrap.
  logic signed [48:0] dxcs2, dyss2, dycs2, dxss2;
  logic signed [31:0] tcc2, tss2, tsc2, tcs2;
  logic signed [17:0] th2;

  always_ff @(posedge clk) begin
    dxcs2 <= dx1 * cs1;
    dyss2 <= dy1 * ss1;
    dycs2 <= dy1 * cs1;
    dxss2 <= dx1 * ss1;
    tcc2  <= cg1 * cs1;
    tss2  <= sg1 * ss1;
    tsc2  <= sg1 * cs1;
    tcs2  <= cg1 * ss1;
    if (th1 >= 17'sd25736) th2 <= {th1[16], th1} - 18'sd51472;
    else if (th1 < -17'sd25736) th2 <= {th1[16], th1} + 18'sd51472;
    else th2 <= {th1[16], th1};
  end

  // Stage 3: rounded relative position and relative tangent.
  logic signed [49:0] px_sum, py_sum;
  logic signed [35:0] px3, py3;
  logic signed [32:0] tx3, ty3;
  logic signed [17:0] th3;

  assign px_sum = {dxcs2[48], dxcs2} + {dyss2[48], dyss2} + 50'sd8192;
  assign py_sum = {dycs2[48], dycs2} - {dxss2[48], dxss2} + 50'sd8192;

  always_ff @(posedge clk) begin
    px3 <= px_sum[49:14];
    py3 <= py_sum[49:14];
    tx3 <= {tcc2[31], tcc2} + {tss2[31], tss2};
    ty3 <= {tsc2[31], tsc2} - {tcs2[31], tcs2};
    th3 <= th2;
  end

  // Stage 4: mirror into the first quadrant, reject and straight tests.
  logic               xs_c, ys_c, flip_c;
  logic signed [35:0] pxa_c, pya_c;
  logic signed [17:0] th4_c;
  logic signed [33:0] om_c;
  logic [PX_W-1:0]    pya4;
  logic signed [32:0] tx4, ty4;
  logic [DEN_W-1:0]   om4;
  side1_t             s4;

  always_comb begin
    xs_c   = py3[35];
    ys_c   = px3[35];
    flip_c = xs_c ^ ys_c;
    pxa_c  = ys_c ? -px3 : px3;
    pya_c  = xs_c ? -py3 : py3;
    th4_c  = flip_c ? -th3 : th3;
    om_c   = 34'sd268435456 - {tx3[32], tx3};
  end

  always_ff @(posedge clk) begin
    pya4        <= pya_c[PX_W-1:0];
    tx4         <= tx3;
    ty4         <= flip_c ? -ty3 : ty3;
    om4         <= om_c[DEN_W-1:0];
    s4.reject   <= th4_c[17] || (th4_c > 18'sd25736);
    s4.straight <= om_c < 34'sd268;
    s4.py_pos   <= pya_c != '0;
    s4.xs       <= xs_c;
    s4.ys       <= ys_c;
    s4.px       <= pxa_c[PX_W-1:0];
    s4.th       <= th4_c[TH_W-1:0];
  end

  // Stage 5: numerator products.
  logic signed [67:0] pyty5, pxty5, pytx5;
  logic [PX_W-1:0]    pya5;
  logic [DEN_W-1:0]   om5;
  side1_t             s5;

  always_ff @(posedge clk) begin
    pyty5 <= $signed({1'b0, pya4}) * ty4;
    pxty5 <= $signed({1'b0, s4.px}) * ty4;
    pytx5 <= $signed({1'b0, pya4}) * tx4;
    pya5  <= pya4;
    om5   <= om4;
    s5    <= s4;
  end

  // Stage 6: arc-first numerator.
  logic signed [67:0] nq6, n26;
  logic [PX_W-1:0]    pya6;
  logic [DEN_W-1:0]   om6;
  side1_t             s6;

  always_ff @(posedge clk) begin
    nq6  <= pyty5;
    n26  <= pxty5 - pytx5;
    pya6 <= pya5;
    om6  <= om5;
    s6   <= s5;
  end

  // Stage 7: sign and magnitude for the dividers.
  logic signed [67:0] nq_abs, n2_abs;

  assign nq_abs = nq6[67] ? -nq6 : nq6;
  assign n2_abs = n26[67] ? -n26 : n26;

  always_ff @(posedge clk) begin
    nq_mag <= nq_abs[NUM_W-1:0];
    nq_neg <= nq6[67];
    n2_mag <= n2_abs[NUM_W-1:0];
    n2_neg <= n26[67];
    nr_mag <= {{(NUM_W-PX_W-28){1'b0}}, pya6, 28'd0};
    om     <= om6;
    side   <= s6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; out_valid <= v6;
    end
  end

endmodule

FILE: hdl/clc_sel.sv
// ============================================================================
// clc_sel - choice between line-then-arc and arc-then-line
// Three register stages: line length and radius tests, path choice, then
// arc length product and curvature divider operand.
// ============================================================================
module clc_sel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [clc_pkg::QUO_W-1:0] q,
  input  logic signed [clc_pkg::QUO_W-1:0] r,
  input  logic signed [clc_pkg::QUO_W-1:0] r2,
  input  clc_pkg::side1_t             side_in,
  input  logic [30:0]                 min_radius,
  output logic                        out_valid,
  output logic [clc_pkg::CRV_W-1:0]   den,
  output clc_pkg::side2_t             side_out
);
  import clc_pkg::*;

  logic ve, vf;

  // Stage E: line length and radius limits.
  logic signed [LEN_W-1:0] l1e;
  logic                    r_ge, r2_ge;
  logic signed [QUO_W-1:0] re, r2e;
  side1_t                  se;

  always_ff @(posedge clk) begin
    l1e   <= $signed({{(LEN_W-PX_W){1'b0}}, side_in.px}) - $signed({q[QUO_W-1], q});
    r_ge  <= r  >= $signed({{(QUO_W-31){1'b0}}, min_radius});
    r2_ge <= r2 >= $signed({{(QUO_W-31){1'b0}}, min_radius});
    re    <= r;
    r2e   <= r2;
    se    <= side_in;
  end

  // Stage F: pick the path shape.
  logic                    lf_c, alt_c;
  logic                    found_f, straight_f, lf_f, xs_f, ys_f;
  logic signed [LEN_W-1:0] len_f;
  logic signed [QUO_W-1:0] rsel;
  logic [TH_W-1:0]         th_f;

  assign lf_c  = r_ge && !l1e[LEN_W-1];
  assign alt_c = (l1e[LEN_W-1] || (l1e == '0)) && r2_ge;

  always_ff @(posedge clk) begin
    found_f    <= !se.reject && (se.straight ? !se.py_pos : (lf_c || alt_c));
    straight_f <= se.straight;
    lf_f       <= lf_c;
    xs_f       <= se.xs;
    ys_f       <= se.ys;
    rsel       <= lf_c ? re : r2e;
    th_f       <= se.th;
    if (se.straight) len_f <= $signed({{(LEN_W-PX_W){1'b0}}, se.px});
    else if (lf_c) len_f <= l1e;
    else len_f <= -l1e;
  end

  // Stage G: arc length product and curvature operand.
  always_ff @(posedge clk) begin
    side_out.found      <= found_f;
    side_out.straight   <= straight_f;
    side_out.line_lead  <= lf_f;
    side_out.xs         <= xs_f;
    side_out.ys         <= ys_f;
    side_out.len        <= len_f;
    side_out.arc_zero   <= (th_f == '0) || rsel[QUO_W-1] || (rsel == '0);
    side_out.arc_big    <= rsel[QUO_W-1:RAD_W] != '0;
    side_out.prod       <= rsel[RAD_W-1:0] * {{RAD_W{1'b0}}, th_f};
    side_out.csat       <= rsel <= $signed(QUO_W'(2));
    side_out.czero      <= rsel > $signed(QUO_W'(64'h1_0000_0000));
    den                 <= rsel[CRV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0; vf <= 1'b0; out_valid <= 1'b0;
    end else begin
      ve <= in_valid; vf <= ve; out_valid <= vf;
    end
  end

endmodule

FILE: hdl/circle_line_connection.sv
// ============================================================================
// circle_line_connection - line/arc connection between two planar poses
// Top level: configuration port, pose pipeline, dividers and result output.
// ============================================================================
// A fully pipelined block: a pose pair is taken whenever start is high and
// busy is low, one pair in every clock cycle, and its answer appears on the
// result ports with done high. busy is high during reset and in the first
// cycle after it. The receiver cannot hold results off, so nothing here ever
// stalls. The latency is set by the two pipelined dividers in series: the
// 64-stage floor divider for the radius and line-length quotients and the
// 33-stage curvature divider, plus the transform, selection and output
// stages around them.
module circle_line_connection (
  input  logic                clk,
  input  logic                rst,
  // Command channel.
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic signed [15:0]  start_heading,
  input  logic signed [15:0]  start_cos,
  input  logic signed [15:0]  start_sin,
  input  logic signed [31:0]  goal_x,
  input  logic signed [31:0]  goal_y,
  input  logic signed [15:0]  goal_heading,
  input  logic signed [15:0]  goal_cos,
  input  logic signed [15:0]  goal_sin,
  // Result channel.
  output logic                done,
  output logic                path_found,
  output logic [1:0]          segment_count,
  output logic [1:0]          first_kind,
  output logic [1:0]          second_kind,
  output logic signed [31:0]  first_length,
  output logic signed [31:0]  second_length,
  output logic [30:0]         first_curvature,
  output logic [30:0]         second_curvature,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import clc_pkg::*;

  // Only one register exists, at byte address zero.
  localparam logic REG_MIN_RADIUS = 1'b0;

  logic [30:0] min_turn_radius;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_turn_radius <= 31'd327680;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MIN_RADIUS)) begin
      min_turn_radius <= pwdata[30:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_RADIUS) ? {1'b0, min_turn_radius} : '0;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Front end: relative pose and divider operands.
  logic               f_valid;
  logic [NUM_W-1:0]   nq_mag, nr_mag, n2_mag;
  logic               nq_neg, n2_neg;
  logic [DEN_W-1:0]   om;
  side1_t             f_side;

  clc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .start_x       (start_x),
    .start_y       (start_y),
    .start_heading (start_heading),
    .start_cos     (start_cos),
    .start_sin     (start_sin),
    .goal_x        (goal_x),
    .goal_y        (goal_y),
    .goal_heading  (goal_heading),
    .goal_cos      (goal_cos),
    .goal_sin      (goal_sin),
    .out_valid     (f_valid),
    .nq_mag        (nq_mag),
    .nq_neg        (nq_neg),
    .nr_mag        (nr_mag),
    .n2_mag        (n2_mag),
    .n2_neg        (n2_neg),
    .om            (om),
    .side          (f_side)
  );

  // Three floor dividers by 1 - cos: line-first offset, line-first radius and
  // arc-first radius. The sideband delay matches their latency.
  logic signed [QUO_W-1:0] q_quo, r_quo, r2_quo;
  logic                    d_valid;
  side1_t                  d_side;

  clc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_q (
    .clk (clk), .num (nq_mag), .neg (nq_neg), .den (om), .quo (q_quo)
  );

  clc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_r (
    .clk (clk), .num (nr_mag), .neg (1'b0), .den (om), .quo (r_quo)
  );

  clc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_r2 (
    .clk (clk), .num (n2_mag), .neg (n2_neg), .den (om), .quo (r2_quo)
  );

  clc_dly #(.W($bits(side1_t)), .DEPTH(NUM_W + 1)) u_dly_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_data   (f_side),
    .out_valid (d_valid),
    .out_data  (d_side)
  );

  // Path choice and curvature operand.
  logic             s_valid;
  logic [CRV_W-1:0] crv_den;
  side2_t           s_side;

  clc_sel u_sel (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .q          (q_quo),
    .r          (r_quo),
    .r2         (r2_quo),
    .side_in    (d_side),
    .min_radius (min_turn_radius),
    .out_valid  (s_valid),
    .den        (crv_den),
    .side_out   (s_side)
  );

  // Curvature is 2^32 over the radius, truncated.
  logic signed [CRV_W:0] crv_quo;
  logic                  c_valid;
  side2_t                c_side;

  clc_div #(.NUM_W(CRV_W), .DEN_W(CRV_W)) u_div_crv (
    .clk (clk),
    .num ({1'b1, {(CRV_W-1){1'b0}}}),
    .neg (1'b0),
    .den (crv_den),
    .quo (crv_quo)
  );

  clc_dly #(.W($bits(side2_t)), .DEPTH(CRV_W + 1)) u_dly_crv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_data   (s_side),
    .out_valid (c_valid),
    .out_data  (c_side)
  );

  // Stage H: arc length rounding and curvature limits.
  logic [PROD_W:0] prod_rnd;
  logic            h_valid;
  logic [47:0]     arc_h;
  logic [30:0]     crv_h;
  side2_t          h_side;

  assign prod_rnd = {1'b0, c_side.prod} + (PROD_W + 1)'(4096);

  always_ff @(posedge clk) begin
    if (c_side.arc_zero) arc_h <= '0;
    else if (c_side.arc_big) arc_h <= 48'h0000_8000_0000;
    else arc_h <= 48'(prod_rnd[PROD_W:13]);
    if (c_side.csat) crv_h <= 31'h7FFF_FFFF;
    else if (c_side.czero) crv_h <= '0;
    else crv_h <= crv_quo[30:0];
    h_side <= c_side;
  end

  // Stage I: order the segments, apply backward motion, saturate.
  function automatic logic signed [31:0] sat32(input logic signed [LEN_W:0] v);
    if (v > $signed((LEN_W + 1)'(32'h7FFF_FFFF))) return 32'sh7FFF_FFFF;
    if (v < -$signed((LEN_W + 1)'(33'h0_8000_0000))) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic signed [LEN_W:0] arc_s, line_s, len0_c, len1_c;
  kind_t                 arc_kind;

  always_comb begin
    arc_s    = $signed({{(LEN_W - 47){1'b0}}, arc_h});
    line_s   = {h_side.len[LEN_W-1], h_side.len};
    arc_kind = h_side.xs ? KIND_RIGHT : KIND_LEFT;
    if (h_side.straight) begin
      len0_c = line_s;
      len1_c = '0;
    end else if (h_side.line_lead) begin
      len0_c = line_s;
      len1_c = arc_s;
    end else begin
      len0_c = arc_s;
      len1_c = line_s;
    end
    if (h_side.ys) begin
      len0_c = -len0_c;
      len1_c = -len1_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!h_side.found) begin
      path_found       <= 1'b0;
      segment_count    <= 2'd0;
      first_kind       <= KIND_STRAIGHT;
      second_kind      <= KIND_STRAIGHT;
      first_length     <= '0;
      second_length    <= '0;
      first_curvature  <= '0;
      second_curvature <= '0;
    end else if (h_side.straight) begin
      path_found       <= 1'b1;
      segment_count    <= 2'd1;
      first_kind       <= KIND_STRAIGHT;
      second_kind      <= KIND_STRAIGHT;
      first_length     <= sat32(len0_c);
      second_length    <= '0;
      first_curvature  <= '0;
      second_curvature <= '0;
    end else begin
      path_found       <= 1'b1;
      segment_count    <= 2'd2;
      first_kind       <= h_side.line_lead ? KIND_STRAIGHT : arc_kind;
      second_kind      <= h_side.line_lead ? arc_kind : KIND_STRAIGHT;
      first_length     <= sat32(len0_c);
      second_length    <= sat32(len1_c);
      first_curvature  <= h_side.line_lead ? 31'd0 : crv_h;
      second_curvature <= h_side.line_lead ? crv_h : 31'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      h_valid <= c_valid;
      done    <= h_valid;
    end
  end

endmodule
